/* hdl/assert_macros.svh */
// Assertion macros used by the segment prime sieve datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SPS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define SPS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/sps_pkg.sv */
// Types, constants and command codes shared by the segment prime sieve modules.
package sps_pkg;

   localparam int VALUE_W          = 32;
   localparam int EXT_W            = 34;
   localparam int BASE_DEPTH       = 65536;
   localparam int BASE_AW          = 16;
   localparam int ROOT_W           = 9;
   localparam int P_W              = 17;
   localparam int PP_W             = 34;
   localparam int DIV_STEPS        = 34;
   localparam int DCNT_W           = 6;
   localparam int MAX_RESULTS      = 55;
   localparam int RES_W            = 6;
   localparam int DEF_SEGMENT_SPAN = 256;
   localparam int DEF_VALUE_BITS   = 32;

   typedef enum logic [4:0] {
      ST_IDLE, ST_BFILL, ST_BREAD, ST_BCHK, ST_BMARK, ST_SINIT, ST_OFILL, ST_PINIT,
      ST_PREAD, ST_PCHK, ST_DSTEP, ST_MUL, ST_FIX1, ST_FIX2, ST_FIX3, ST_OMARK,
      ST_CINIT, ST_CREAD, ST_CCHK, ST_EINIT, ST_EWAIT, ST_EREAD, ST_ECHK
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_BFILL, CMD_BREAD, CMD_BCHK, CMD_BMARK, CMD_OINIT,
      CMD_OFILL, CMD_PINIT, CMD_PREAD, CMD_PNEXT, CMD_DSTART, CMD_DSTEP, CMD_MUL,
      CMD_FIX1, CMD_FIX2, CMD_FIX3, CMD_OMARK, CMD_CINIT, CMD_CREAD, CMD_CCHK,
      CMD_EINIT, CMD_EREAD, CMD_ECHK
   } cmd_type;

   typedef struct packed {
      logic base_mark;
      logic bfill_last;
      logic i_last;
      logic bmark_last;
      logic has_odd;
      logic ofill_last;
      logic p_done;
      logic div_last;
      logic idx_in_range;
      logic odd_mark;
      logic scan_last;
      logic emit_done;
      logic out_pending;
   } status_type;

endpackage

/* hdl/sps_ctrl.sv */
// Controller state machine that sequences the base sieve, segment sieve and result run.
module sps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sps_pkg::status_type status,
   output sps_pkg::cmd_type    cmd
);

   sps_pkg::state_type state_ff, state_in;
   logic               base_ready_ff, base_ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sps_pkg::ST_IDLE;
         base_ready_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ready_ff <= base_ready_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = sps_pkg::CMD_NONE;
      req_tready    = 1'b0;
      base_ready_in = base_ready_ff || (state_ff == sps_pkg::ST_SINIT);
      case (state_ff)
         sps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = sps_pkg::CMD_LOAD;
               state_in = base_ready_ff ? sps_pkg::ST_SINIT : sps_pkg::ST_BFILL;
            end
         end
         sps_pkg::ST_BFILL: begin
            cmd = sps_pkg::CMD_BFILL;
            if (status.bfill_last) state_in = sps_pkg::ST_BREAD;
         end
         sps_pkg::ST_BREAD: begin
            cmd      = sps_pkg::CMD_BREAD;
            state_in = sps_pkg::ST_BCHK;
         end
         sps_pkg::ST_BCHK: begin
            cmd = sps_pkg::CMD_BCHK;
            if (status.base_mark) state_in = sps_pkg::ST_BMARK;
            else if (status.i_last) state_in = sps_pkg::ST_SINIT;
            else state_in = sps_pkg::ST_BREAD;
         end
         sps_pkg::ST_BMARK: begin
            cmd = sps_pkg::CMD_BMARK;
            if (status.bmark_last) begin
               state_in = status.i_last ? sps_pkg::ST_SINIT : sps_pkg::ST_BREAD;
            end
         end
         sps_pkg::ST_SINIT: begin
            cmd      = sps_pkg::CMD_OINIT;
            state_in = status.has_odd ? sps_pkg::ST_OFILL : sps_pkg::ST_CINIT;
         end
         sps_pkg::ST_OFILL: begin
            cmd = sps_pkg::CMD_OFILL;
            if (status.ofill_last) state_in = sps_pkg::ST_PINIT;
         end
         sps_pkg::ST_PINIT: begin
            cmd      = sps_pkg::CMD_PINIT;
            state_in = sps_pkg::ST_PREAD;
         end
         sps_pkg::ST_PREAD: begin
            cmd      = sps_pkg::CMD_PREAD;
            state_in = sps_pkg::ST_PCHK;
         end
         sps_pkg::ST_PCHK: begin
            if (status.p_done) begin
               state_in = sps_pkg::ST_CINIT;
            end else if (!status.base_mark) begin
               cmd      = sps_pkg::CMD_PNEXT;
               state_in = sps_pkg::ST_PREAD;
            end else begin
               cmd      = sps_pkg::CMD_DSTART;
               state_in = sps_pkg::ST_DSTEP;
            end
         end
         sps_pkg::ST_DSTEP: begin
            cmd = sps_pkg::CMD_DSTEP;
            if (status.div_last) state_in = sps_pkg::ST_MUL;
         end
         sps_pkg::ST_MUL: begin
            cmd      = sps_pkg::CMD_MUL;
            state_in = sps_pkg::ST_FIX1;
         end
         sps_pkg::ST_FIX1: begin
            cmd      = sps_pkg::CMD_FIX1;
            state_in = sps_pkg::ST_FIX2;
         end
         sps_pkg::ST_FIX2: begin
            cmd      = sps_pkg::CMD_FIX2;
            state_in = sps_pkg::ST_FIX3;
         end
         sps_pkg::ST_FIX3: begin
            cmd      = sps_pkg::CMD_FIX3;
            state_in = sps_pkg::ST_OMARK;
         end
         sps_pkg::ST_OMARK: begin
            if (status.idx_in_range) begin
               cmd = sps_pkg::CMD_OMARK;
            end else begin
               cmd      = sps_pkg::CMD_PNEXT;
               state_in = sps_pkg::ST_PREAD;
            end
         end
         sps_pkg::ST_CINIT: begin
            cmd      = sps_pkg::CMD_CINIT;
            state_in = status.has_odd ? sps_pkg::ST_CREAD : sps_pkg::ST_EINIT;
         end
         sps_pkg::ST_CREAD: begin
            cmd      = sps_pkg::CMD_CREAD;
            state_in = sps_pkg::ST_CCHK;
         end
         sps_pkg::ST_CCHK: begin
            cmd      = sps_pkg::CMD_CCHK;
            state_in = status.scan_last ? sps_pkg::ST_EINIT : sps_pkg::ST_CREAD;
         end
         sps_pkg::ST_EINIT: begin
            if (!status.out_pending) begin
               cmd      = sps_pkg::CMD_EINIT;
               state_in = sps_pkg::ST_EWAIT;
            end
         end
         sps_pkg::ST_EWAIT: begin
            if (!status.out_pending) state_in = sps_pkg::ST_EREAD;
         end
         sps_pkg::ST_EREAD: begin
            if (status.emit_done) begin
               state_in = sps_pkg::ST_IDLE;
            end else begin
               cmd      = sps_pkg::CMD_EREAD;
               state_in = sps_pkg::ST_ECHK;
            end
         end
         sps_pkg::ST_ECHK: begin
            cmd      = sps_pkg::CMD_ECHK;
            state_in = status.odd_mark ? sps_pkg::ST_EWAIT : sps_pkg::ST_EREAD;
         end
         default: begin
            state_in = sps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/sps_datapath.sv */
// Datapath with the base and segment mark memories, the divider and the result register.
`include "assert_macros.svh"

module sps_datapath #(
   parameter int SEGMENT_SPAN = sps_pkg::DEF_SEGMENT_SPAN,
   parameter int VALUE_BITS   = sps_pkg::DEF_VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sps_pkg::VALUE_W-1:0]   req_tdata,
   input  sps_pkg::cmd_type              cmd,
   output sps_pkg::status_type           status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sps_pkg::VALUE_W-1:0]   rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int ODD_DEPTH = (SEGMENT_SPAN + 1) / 2;
   localparam int ODD_AW    = $clog2(ODD_DEPTH);
   localparam int N_W       = ODD_AW + 1;
   localparam int LIM_BITS  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int PROD_W    = sps_pkg::VALUE_W + 1 + sps_pkg::P_W;
   localparam int EW        = sps_pkg::EXT_W;
   localparam logic [sps_pkg::RES_W-1:0] RES_MAX = sps_pkg::RES_W'(sps_pkg::MAX_RESULTS);

   // Segment bounds.
   logic [EW-1:0]               end_ff;
   logic [sps_pkg::VALUE_W-1:0] lo_ff;
   logic [N_W-1:0]              n_ff;
   logic                        emit2_ff;
   logic                        has_odd_ff;

   logic [EW-1:0] s_ext, s2, end_raw, limit, end_c, lo_c, diff_c;
   logic          has_odd_c;

   always_comb begin
      s_ext     = {2'b00, req_tdata};
      s2        = (s_ext < EW'(2)) ? EW'(2) : s_ext;
      end_raw   = s2 + EW'(SEGMENT_SPAN);
      limit     = EW'(1) << LIM_BITS;
      end_c     = (end_raw > limit) ? limit : end_raw;
      lo_c      = s2 | EW'(1);
      has_odd_c = lo_c < end_c;
      diff_c    = end_c - lo_c + EW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd == sps_pkg::CMD_LOAD) begin
         end_ff     <= end_c;
         lo_ff      <= lo_c[sps_pkg::VALUE_W-1:0];
         has_odd_ff <= has_odd_c;
         n_ff       <= has_odd_c ? N_W'(diff_c >> 1) : '0;
         emit2_ff   <= (s2 <= EW'(2)) && (end_c > EW'(2));
      end
   end

   // Base prime table.
   logic                       base_mem_ff [sps_pkg::BASE_DEPTH];
   logic                       base_rd_ff;
   logic [sps_pkg::BASE_AW:0]  j_ff;
   logic [sps_pkg::BASE_AW:0]  j_next;
   logic [sps_pkg::ROOT_W-1:0] i_ff;
   logic [2*sps_pkg::ROOT_W-1:0] i_sq;
   logic                       base_we, base_wd, base_re;
   logic [sps_pkg::BASE_AW-1:0] base_wa, base_ra;

   logic [sps_pkg::P_W-1:0]  p_ff;
   logic [sps_pkg::PP_W-1:0] pp_ff;

   assign j_next = j_ff + (sps_pkg::BASE_AW + 1)'(i_ff);
   assign i_sq   = i_ff * i_ff;

   always_comb begin
      base_we = (cmd == sps_pkg::CMD_BFILL) || (cmd == sps_pkg::CMD_BMARK);
      base_wa = j_ff[sps_pkg::BASE_AW-1:0];
      base_wd = (cmd == sps_pkg::CMD_BFILL) && (j_ff >= (sps_pkg::BASE_AW + 1)'(2));
      base_re = (cmd == sps_pkg::CMD_BREAD) || (cmd == sps_pkg::CMD_PREAD);
      base_ra = (cmd == sps_pkg::CMD_BREAD) ? sps_pkg::BASE_AW'(i_ff)
                                            : p_ff[sps_pkg::BASE_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (base_we) base_mem_ff[base_wa] <= base_wd;
      if (base_re) base_rd_ff <= base_mem_ff[base_ra];
   end

   always_ff @(posedge clock) begin
      case (cmd)
         sps_pkg::CMD_LOAD:  j_ff <= '0;
         sps_pkg::CMD_BFILL: begin
            j_ff <= j_ff + (sps_pkg::BASE_AW + 1)'(1);
            i_ff <= sps_pkg::ROOT_W'(2);
         end
         sps_pkg::CMD_BCHK: begin
            if (base_rd_ff) j_ff <= (sps_pkg::BASE_AW + 1)'(i_sq);
            else i_ff <= i_ff + sps_pkg::ROOT_W'(1);
         end
         sps_pkg::CMD_BMARK: begin
            j_ff <= j_next;
            if (j_next[sps_pkg::BASE_AW]) i_ff <= i_ff + sps_pkg::ROOT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Divider, multiplier and start index.
   logic [EW-1:0]            quot_ff, first_ff, idx_ff;
   logic [sps_pkg::P_W:0]    rem_ff, rem_sh;
   logic                     rem_ge;
   logic [sps_pkg::DCNT_W-1:0] dcnt_ff;
   logic [PROD_W-1:0]        prod;

   assign rem_sh = {rem_ff[sps_pkg::P_W-1:0], quot_ff[EW-1]};
   assign rem_ge = rem_sh >= {1'b0, p_ff};
   assign prod   = quot_ff[sps_pkg::VALUE_W:0] * p_ff;

   always_ff @(posedge clock) begin
      case (cmd)
         sps_pkg::CMD_PINIT: p_ff <= sps_pkg::P_W'(3);
         sps_pkg::CMD_PREAD: pp_ff <= p_ff * p_ff;
         sps_pkg::CMD_PNEXT: p_ff <= p_ff + sps_pkg::P_W'(2);
         sps_pkg::CMD_DSTART: begin
            quot_ff <= {2'b00, lo_ff} + EW'(p_ff) - EW'(1);
            rem_ff  <= '0;
            dcnt_ff <= '0;
         end
         sps_pkg::CMD_DSTEP: begin
            rem_ff  <= rem_ge ? (rem_sh - {1'b0, p_ff}) : rem_sh;
            quot_ff <= {quot_ff[EW-2:0], rem_ge};
            dcnt_ff <= dcnt_ff + sps_pkg::DCNT_W'(1);
         end
         sps_pkg::CMD_MUL:  first_ff <= prod[EW-1:0];
         sps_pkg::CMD_FIX1: if (first_ff < pp_ff) first_ff <= pp_ff;
         sps_pkg::CMD_FIX2: if (!first_ff[0]) first_ff <= first_ff + EW'(p_ff);
         sps_pkg::CMD_FIX3: idx_ff <= (first_ff - {2'b00, lo_ff}) >> 1;
         sps_pkg::CMD_OMARK: idx_ff <= idx_ff + EW'(p_ff);
         default: begin
         end
      endcase
   end

   // Segment marks, count and emission.
   logic              odd_mem_ff [ODD_DEPTH];
   logic              odd_rd_ff;
   logic [N_W-1:0]    k_ff;
   logic              odd_we, odd_wd;
   logic [ODD_AW-1:0] odd_wa;
   logic [sps_pkg::RES_W-1:0] total_ff, emitted_ff;

   always_comb begin
      odd_we = (cmd == sps_pkg::CMD_OFILL) || (cmd == sps_pkg::CMD_OMARK);
      odd_wd = (cmd == sps_pkg::CMD_OFILL);
      odd_wa = (cmd == sps_pkg::CMD_OFILL) ? k_ff[ODD_AW-1:0] : idx_ff[ODD_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (odd_we) odd_mem_ff[odd_wa] <= odd_wd;
      if ((cmd == sps_pkg::CMD_CREAD) || (cmd == sps_pkg::CMD_EREAD)) begin
         odd_rd_ff <= odd_mem_ff[k_ff[ODD_AW-1:0]];
      end
   end

   logic                        rsp_tvalid_ff;
   logic [sps_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                        rsp_flag_ff, rsp_last_ff;
   logic                        load_hit;
   logic                        omark_hit;

   always_ff @(posedge clock) begin
      case (cmd)
         sps_pkg::CMD_OINIT, sps_pkg::CMD_CINIT, sps_pkg::CMD_EINIT: k_ff <= '0;
         sps_pkg::CMD_OFILL, sps_pkg::CMD_CCHK, sps_pkg::CMD_ECHK:
            k_ff <= k_ff + N_W'(1);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         emitted_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_ff <= 1'b0;
         case (cmd)
            sps_pkg::CMD_CINIT: begin
               total_ff   <= sps_pkg::RES_W'(emit2_ff);
               emitted_ff <= '0;
            end
            sps_pkg::CMD_CCHK: begin
               if (odd_rd_ff && (total_ff < RES_MAX)) begin
                  total_ff <= total_ff + sps_pkg::RES_W'(1);
               end
            end
            sps_pkg::CMD_EINIT: begin
               if (total_ff == '0) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_value_ff  <= '0;
                  rsp_flag_ff   <= 1'b0;
                  rsp_last_ff   <= 1'b1;
               end else if (emit2_ff) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_value_ff  <= sps_pkg::VALUE_W'(2);
                  rsp_flag_ff   <= 1'b1;
                  rsp_last_ff   <= (total_ff == sps_pkg::RES_W'(1));
                  emitted_ff    <= sps_pkg::RES_W'(1);
               end
            end
            sps_pkg::CMD_ECHK: begin
               if (odd_rd_ff) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_value_ff  <= lo_ff + sps_pkg::VALUE_W'({k_ff, 1'b0});
                  rsp_flag_ff   <= 1'b1;
                  rsp_last_ff   <= ((emitted_ff + sps_pkg::RES_W'(1)) == total_ff);
                  emitted_ff    <= emitted_ff + sps_pkg::RES_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign load_hit  = (cmd == sps_pkg::CMD_ECHK) && odd_rd_ff;
   assign omark_hit = (cmd == sps_pkg::CMD_OMARK);

   always_comb begin
      status.base_mark    = base_rd_ff;
      status.bfill_last   = (j_ff == (sps_pkg::BASE_AW + 1)'(sps_pkg::BASE_DEPTH - 1));
      status.i_last       = (i_ff == sps_pkg::ROOT_W'(255));
      status.bmark_last   = j_next[sps_pkg::BASE_AW];
      status.has_odd      = has_odd_ff;
      status.ofill_last   = (k_ff == (n_ff - N_W'(1)));
      status.p_done       = p_ff[sps_pkg::P_W-1] || (pp_ff >= end_ff);
      status.div_last     = (dcnt_ff == sps_pkg::DCNT_W'(sps_pkg::DIV_STEPS - 1));
      status.idx_in_range = (idx_ff < EW'(n_ff));
      status.odd_mark     = odd_rd_ff;
      status.scan_last    = (k_ff == (n_ff - N_W'(1)));
      status.emit_done    = (emitted_ff == total_ff);
      status.out_pending  = rsp_tvalid_ff;
   end

   `SPS_ASSERT_ALWAYS(a_emit_bound, clock, reset, emitted_ff <= total_ff, "too many results sent")
   `SPS_ASSERT_ALWAYS(a_total_bound, clock, reset, total_ff <= RES_MAX, "result count over limit")
   `SPS_ASSERT_IMPLY(a_load_free, clock, reset, load_hit, !rsp_tvalid_ff, "result overwritten")
   `SPS_ASSERT_IMPLY(a_mark_range, clock, reset, omark_hit, idx_ff < EW'(n_ff), "mark off segment")

endmodule

/* hdl/segment_prime_sieve_unit.sv */
// The first item after reset builds the 65536-entry base table once.
// Each segment then reads every odd base candidate below the root of the range end, and for
// each odd base prime runs the 34-step divider and the start index, then writes its marks.
// One item is in work at a time.
// Results leave one at a time, paced by the result register and mark memory read.
// Reset is synchronous and active high; the base table is rebuilt on the first item after it.
module segment_prime_sieve_unit #(
   parameter int SEGMENT_SPAN = sps_pkg::DEF_SEGMENT_SPAN,
   parameter int VALUE_BITS   = sps_pkg::DEF_VALUE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sps_pkg::VALUE_W-1:0] req_tdata,   // segment_start
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [sps_pkg::VALUE_W-1:0] rsp_tdata,   // prime_value
   output logic                        rsp_tuser,   // prime_valid
   output logic                        rsp_tlast
);

   sps_pkg::cmd_type    cmd;
   sps_pkg::status_type status;

   sps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sps_datapath #(
      .SEGMENT_SPAN (SEGMENT_SPAN),
      .VALUE_BITS   (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
